[src/srg_pkg.sv]
// Shared constants, types and helpers of the seeded region grower.
// Used by every module in src; depends on nothing else.
package srg_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 256;
  localparam int MAX_REGIONS = 63;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int PIX_W  = 8;
  localparam int CNT_W  = 15;
  localparam int DIM_W  = 9;
  localparam int OUT_W  = 8;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = 15'd32767;

  // Register indexes of the write port.
  localparam logic [1:0] REG_ROWS      = 2'd0;
  localparam logic [1:0] REG_COLS      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_SEED      = 2'd3;

  localparam logic [DIM_W-1:0] ROWS_RST      = 9'd256;
  localparam logic [DIM_W-1:0] COLS_RST      = 9'd256;
  localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd127;
  localparam logic [PIX_W-1:0] SEED_RST      = 8'd0;

  // Step codes for one neighbor coordinate.
  localparam logic [1:0] STEP_STAY = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  // Frame memory request from the sequencer.
  typedef struct packed {
    logic              pix_we;
    logic              mask_we;
    logic              mask_bit;
    logic [PIX_W-1:0]  pix_data;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
  } fm_req_t;

  // Row step of neighbor dir, raster order around the center.
  function automatic logic [1:0] nb_row_step(input logic [2:0] dir);
    logic [1:0] s;
    case (dir)
      3'd0, 3'd1, 3'd2: s = STEP_DEC;
      3'd3, 3'd4:       s = STEP_STAY;
      default:          s = STEP_INC;
    endcase
    return s;
  endfunction

  // Column step of neighbor dir.
  function automatic logic [1:0] nb_col_step(input logic [2:0] dir);
    logic [1:0] s;
    case (dir)
      3'd0, 3'd3, 3'd5: s = STEP_DEC;
      3'd1, 3'd6:       s = STEP_STAY;
      default:          s = STEP_INC;
    endcase
    return s;
  endfunction

  // Last usable index of a dimension, with zero acting as one.
  function automatic logic [11:0] dim_last(input logic [DIM_W-1:0] v, input int maxv);
    logic [11:0] r;
    if (v == '0) r = '0;
    else if (32'(v) > maxv) r = 12'(maxv - 1);
    else r = 12'(32'(v) - 1);
    return r;
  endfunction

endpackage

[src/seeded_region_grow_bbox.sv]
// Seeded 8-connected region grower with bounding boxes: top level and sequencer.
// Pixels load one per cycle while the input is valid; after the frame's last beat
// the mask is cleared, the frame is scanned for seeds, the neighbors of each grown
// pixel are read and checked, and each record waits out any output stall.
// Throughput: one frame at a time; the input is not ready during the walk.
// Reset (rst, synchronous) clears control state and sets the register defaults.
// Depends on srg_pkg, srg_frame_store and srg_walk_queue.
module seeded_region_grow_bbox
  import srg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] gray_pixel
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // [14:0] region_index, [22:15] top_row, [30:23] bottom_row, [38:31] left_col,
  // [46:39] right_col, [61:47] total_regions, [62] overflow, [63] zero
  output logic [63:0] m_tdata,
  output logic        m_tuser,   // is_summary
  output logic        m_tlast    // last_result
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_SCAN_RD, ST_SCAN_CHK, ST_POP, ST_POP_WAIT,
    ST_NB_RD, ST_NB_CHK, ST_EMIT, ST_SUMMARY
  } state_t;

  state_t state;

  logic [DIM_W-1:0] active_rows;
  logic [DIM_W-1:0] active_cols;
  logic [PIX_W-1:0] grow_threshold;
  logic [PIX_W-1:0] seed_level;

  logic [ROW_W-1:0] rows_last, load_row, scan_row, cur_row, nb_row, nb_row_c;
  logic [COL_W-1:0] cols_last, load_col, scan_col, cur_col, nb_col, nb_col_c;
  logic [DIM_W-1:0] cols_n;
  logic [ROW_W-1:0] wr_row, rd_row;
  logic [COL_W-1:0] wr_col, rd_col;
  logic             load_full;
  logic [2:0]       dir;
  logic [CNT_W-1:0] region_counter;
  logic [ROW_W-1:0] box_top, box_bot;
  logic [COL_W-1:0] box_left, box_right;

  fm_req_t           fm_req;
  logic [PIX_W-1:0]  rd_pix;
  logic              rd_mask;
  logic              q_clear, q_push, q_pop, q_empty;
  logic [ADDR_W-1:0] q_push_data, q_rd_data;

  logic scan_last, load_last, out_free, out_load, is_seed, joins, nb_ok, can_emit;
  logic [1:0] rstep, cstep;

  // Raster address of a pixel: row times the active width plus column.
  function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c,
                                                 input logic [DIM_W-1:0] w);
    logic [ROW_W+DIM_W-1:0] prod;
    prod = {{DIM_W{1'b0}}, r} * {{ROW_W{1'b0}}, w};
    return ADDR_W'(prod + {{(ROW_W+DIM_W-COL_W){1'b0}}, c});
  endfunction

  assign rows_last = ROW_W'(dim_last(active_rows, MAX_ROWS));
  assign cols_last = COL_W'(dim_last(active_cols, MAX_COLS));
  assign cols_n    = {1'b0, cols_last} + 1'b1;
  assign scan_last = (scan_row == rows_last) && (scan_col == cols_last);
  assign load_last = (load_row == rows_last) && (load_col == cols_last);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && ((state == ST_EMIT) || (state == ST_SUMMARY));
  assign is_seed   = (rd_pix == seed_level) && !rd_mask;
  assign joins     = !rd_mask && (rd_pix < grow_threshold);
  assign can_emit  = (region_counter < CNT_W'(MAX_REGIONS));
  assign s_tready  = (state == ST_LOAD);

  // Neighbor position and border check.
  always_comb begin
    rstep    = nb_row_step(dir);
    cstep    = nb_col_step(dir);
    nb_row_c = cur_row;
    nb_col_c = cur_col;
    nb_ok    = 1'b1;
    if (rstep == STEP_INC) begin
      nb_row_c = cur_row + 1'b1;
      if (cur_row == rows_last) nb_ok = 1'b0;
    end else if (rstep == STEP_DEC) begin
      nb_row_c = cur_row - 1'b1;
      if (cur_row == '0) nb_ok = 1'b0;
    end
    if (cstep == STEP_INC) begin
      nb_col_c = cur_col + 1'b1;
      if (cur_col == cols_last) nb_ok = 1'b0;
    end else if (cstep == STEP_DEC) begin
      nb_col_c = cur_col - 1'b1;
      if (cur_col == '0) nb_ok = 1'b0;
    end
  end

  // Memory and queue requests from the current state.
  always_comb begin
    fm_req          = '0;
    fm_req.pix_data = s_tdata[PIX_W-1:0];
    rd_row          = nb_row_c;
    rd_col          = nb_col_c;
    wr_row          = nb_row;
    wr_col          = nb_col;
    q_clear         = 1'b0;
    q_push          = 1'b0;
    q_pop           = 1'b0;
    q_push_data     = {nb_row, nb_col};
    case (state)
      ST_LOAD: begin
        fm_req.pix_we = s_tvalid && !load_full;
        wr_row        = load_row;
        wr_col        = load_col;
      end
      ST_CLEAR: begin
        fm_req.mask_we = 1'b1;
        wr_row         = scan_row;
        wr_col         = scan_col;
      end
      ST_SCAN_RD: begin
        rd_row = scan_row;
        rd_col = scan_col;
      end
      ST_SCAN_CHK: begin
        wr_row = scan_row;
        wr_col = scan_col;
        if (is_seed) begin
          fm_req.mask_we  = 1'b1;
          fm_req.mask_bit = 1'b1;
          q_clear         = 1'b1;
          q_push          = 1'b1;
          q_push_data     = {scan_row, scan_col};
        end
      end
      ST_POP: begin
        q_pop = !q_empty;
      end
      ST_NB_CHK: begin
        if (joins) begin
          fm_req.mask_we  = 1'b1;
          fm_req.mask_bit = 1'b1;
          q_push          = 1'b1;
        end
      end
      default: begin
      end
    endcase
    fm_req.wr_addr = pix_addr(wr_row, wr_col, cols_n);
    fm_req.rd_addr = pix_addr(rd_row, rd_col, cols_n);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows    <= ROWS_RST;
      active_cols    <= COLS_RST;
      grow_threshold <= THRESHOLD_RST;
      seed_level     <= SEED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROWS:      active_rows    <= cfg_data;
        REG_COLS:      active_cols    <= cfg_data;
        REG_THRESHOLD: grow_threshold <= cfg_data[PIX_W-1:0];
        REG_SEED:      seed_level     <= cfg_data[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer with output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      load_row       <= '0;
      load_col       <= '0;
      load_full      <= 1'b0;
      scan_row       <= '0;
      scan_col       <= '0;
      dir            <= '0;
      region_counter <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (s_tlast) begin
              load_row       <= '0;
              load_col       <= '0;
              load_full      <= 1'b0;
              scan_row       <= '0;
              scan_col       <= '0;
              region_counter <= '0;
              state          <= ST_CLEAR;
            end else if (!load_full) begin
              if (load_last) load_full <= 1'b1;
              if (load_col == cols_last) begin
                load_col <= '0;
                load_row <= load_row + 1'b1;
              end else begin
                load_col <= load_col + 1'b1;
              end
            end
          end
        end
        ST_CLEAR: begin
          if (scan_last) begin
            scan_row <= '0;
            scan_col <= '0;
            state    <= ST_SCAN_RD;
          end else if (scan_col == cols_last) begin
            scan_col <= '0;
            scan_row <= scan_row + 1'b1;
          end else begin
            scan_col <= scan_col + 1'b1;
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (is_seed) begin
            box_top   <= scan_row;
            box_bot   <= scan_row;
            box_left  <= scan_col;
            box_right <= scan_col;
            state     <= ST_POP;
          end else if (scan_last) begin
            state <= ST_SUMMARY;
          end else begin
            if (scan_col == cols_last) begin
              scan_col <= '0;
              scan_row <= scan_row + 1'b1;
            end else begin
              scan_col <= scan_col + 1'b1;
            end
            state <= ST_SCAN_RD;
          end
        end
        ST_POP: begin
          if (!q_empty) begin
            state <= ST_POP_WAIT;
          end else if (can_emit) begin
            state <= ST_EMIT;
          end else begin
            if (region_counter < COUNT_LIMIT) region_counter <= region_counter + 1'b1;
            if (scan_last) begin
              state <= ST_SUMMARY;
            end else begin
              if (scan_col == cols_last) begin
                scan_col <= '0;
                scan_row <= scan_row + 1'b1;
              end else begin
                scan_col <= scan_col + 1'b1;
              end
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_POP_WAIT: begin
          cur_row <= q_rd_data[ADDR_W-1:COL_W];
          cur_col <= q_rd_data[COL_W-1:0];
          dir     <= '0;
          state   <= ST_NB_RD;
        end
        ST_NB_RD: begin
          nb_row <= nb_row_c;
          nb_col <= nb_col_c;
          if (nb_ok) begin
            state <= ST_NB_CHK;
          end else if (dir == 3'd7) begin
            state <= ST_POP;
          end else begin
            dir <= dir + 1'b1;
          end
        end
        ST_NB_CHK: begin
          if (joins) begin
            if (nb_row < box_top)   box_top   <= nb_row;
            if (nb_row > box_bot)   box_bot   <= nb_row;
            if (nb_col < box_left)  box_left  <= nb_col;
            if (nb_col > box_right) box_right <= nb_col;
          end
          dir   <= dir + 1'b1;
          state <= (dir == 3'd7) ? ST_POP : ST_NB_RD;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b0;
            m_tdata  <= {1'b0, 1'b0, 15'd0, OUT_W'(box_right), OUT_W'(box_left),
                         OUT_W'(box_bot), OUT_W'(box_top), region_counter};
            if (region_counter < COUNT_LIMIT) region_counter <= region_counter + 1'b1;
            if (scan_last) begin
              state <= ST_SUMMARY;
            end else begin
              if (scan_col == cols_last) begin
                scan_col <= '0;
                scan_row <= scan_row + 1'b1;
              end else begin
                scan_col <= scan_col + 1'b1;
              end
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_SUMMARY: begin
          if (out_free) begin
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            m_tdata  <= {1'b0, (region_counter > CNT_W'(MAX_REGIONS)), region_counter,
                         32'd0, 15'd0};
            state    <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  srg_frame_store u_store (
    .clk     (clk),
    .req     (fm_req),
    .rd_pix  (rd_pix),
    .rd_mask (rd_mask)
  );

  srg_walk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .clear     (q_clear),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .empty     (q_empty)
  );

  // The last beat of a run is always a summary beat.
  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("last beat without summary flag");

  // Region records stay below the record limit.
  a_region_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[CNT_W-1:0] < CNT_W'(MAX_REGIONS))
    else $error("region record beyond limit");

  // A finished box is well ordered.
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> (box_top <= box_bot) && (box_left <= box_right))
    else $error("bounding box out of order");

  // The walk queue is drained before a new frame loads.
  a_queue_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUMMARY |-> q_empty)
    else $error("queue not empty at summary");

endmodule

[src/srg_frame_store.sv]
// Frame pixel memory and grown-pixel mask memory, addressed by raster position.
// Depends on srg_pkg.
module srg_frame_store
  import srg_pkg::*;
(
  input  logic             clk,
  input  fm_req_t          req,
  output logic [PIX_W-1:0] rd_pix,
  output logic             rd_mask
);

  logic [PIX_W-1:0] pix_mem  [2**ADDR_W];
  logic             mask_mem [2**ADDR_W];

  // Pixel memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (req.pix_we) begin
      pix_mem[req.wr_addr] <= req.pix_data;
    end
    rd_pix <= pix_mem[req.rd_addr];
  end

  // Mask memory: same addressing.
  always_ff @(posedge clk) begin
    if (req.mask_we) begin
      mask_mem[req.wr_addr] <= req.mask_bit;
    end
    rd_mask <= mask_mem[req.rd_addr];
  end

endmodule

[src/srg_walk_queue.sv]
// First-in first-out queue of pixel positions waiting to be expanded.
// Depends on srg_pkg.
module srg_walk_queue
  import srg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              push,
  input  logic [ADDR_W-1:0] push_data,
  input  logic              pop,
  output logic [ADDR_W-1:0] rd_data,
  output logic              empty
);

  logic [ADDR_W-1:0] mem [2**ADDR_W];
  logic [ADDR_W:0]   head;
  logic [ADDR_W:0]   tail;

  assign empty = (head == tail);

  // Pointers; a clear restarts the queue and may take a push at slot zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (clear) begin
      head <= '0;
      tail <= push ? (ADDR_W+1)'(1) : '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop)  head <= head + 1'b1;
    end
  end

  // Storage with registered read.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[clear ? '0 : tail[ADDR_W-1:0]] <= push_data;
    end
    if (pop) begin
      rd_data <= mem[head[ADDR_W-1:0]];
    end
  end

endmodule

[tb/tb_seeded_region_grow_bbox.sv]
// Self-checking testbench for the seeded region grower with bounding boxes.
// Depends on srg_pkg and the RTL in src; frames are predicted in-bench and results
// are compared beat by beat.
`timescale 1ns / 1ps

module tb_seeded_region_grow_bbox;
  import srg_pkg::*;

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

  typedef struct {
    int unsigned region_index;
    int unsigned top_row;
    int unsigned bottom_row;
    int unsigned left_col;
    int unsigned right_col;
    bit          is_summary;
    int unsigned total_regions;
    bit          overflow;
    bit          last_result;
  } region_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] gray_pixel
  logic        s_tlast;   // frame_end
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // region_index .. overflow, see the block's port list
  logic        m_tuser;   // is_summary
  logic        m_tlast;   // last_result

  seeded_region_grow_bbox u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Predictor state: register copies and the stored frame.
  logic [8:0]  rows_reg;
  logic [8:0]  cols_reg;
  logic [7:0]  thresh_reg;
  logic [7:0]  seed_reg;
  logic [7:0]  frame_pix [CELL_COUNT];
  bit          grown     [CELL_COUNT];
  int          walk_list [CELL_COUNT];
  int          load_pos;
  int          loaded_span;   // addresses [0, loaded_span) hold written pixels

  region_rec_t expected_recs[$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  int          items_sent;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int clamp_dim(logic [8:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Grow one region from a seed and return its box.
  task automatic grow_from_seed(int seed, int rows, int cols, output region_rec_t r);
    int head, tail, q, qr, qc, nr, nc, np;
    head = 0;
    tail = 0;
    grown[seed] = 1;
    walk_list[tail++] = seed;
    r = '{default: 0};
    r.top_row = seed / cols;
    r.bottom_row = seed / cols;
    r.left_col = seed % cols;
    r.right_col = seed % cols;
    while (head < tail) begin
      q = walk_list[head++];
      qr = q / cols;
      qc = q % cols;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          nr = qr + dr;
          nc = qc + dc;
          if (dr == 0 && dc == 0) continue;
          if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
          np = nr * cols + nc;
          if (grown[np] || frame_pix[np] >= thresh_reg) continue;
          grown[np] = 1;
          walk_list[tail++] = np;
          if (nr < r.top_row) r.top_row = nr;
          if (nr > r.bottom_row) r.bottom_row = nr;
          if (nc < r.left_col) r.left_col = nc;
          if (nc > r.right_col) r.right_col = nc;
        end
      end
    end
  endtask

  // Store one accepted pixel; at frame end, scan and queue the records.
  task automatic predict_pixel(logic [7:0] pix, logic fend);
    int rows, cols, n, count;
    region_rec_t r;
    rows = clamp_dim(rows_reg, MAX_ROWS);
    cols = clamp_dim(cols_reg, MAX_COLS);
    n = rows * cols;
    if (load_pos < n) begin
      frame_pix[load_pos] = pix;
      load_pos++;
      if (load_pos > loaded_span) loaded_span = load_pos;
    end
    if (!fend) return;
    load_pos = 0;
    count = 0;
    for (int i = 0; i < CELL_COUNT; i++) grown[i] = 0;
    for (int p = 0; p < n; p++) begin
      if (frame_pix[p] != seed_reg || grown[p]) continue;
      grow_from_seed(p, rows, cols, r);
      if (count < MAX_REGIONS) begin
        r.region_index = count;
        expected_recs.push_back(r);
      end
      if (count < 32767) count++;
    end
    r = '{default: 0};
    r.is_summary = 1;
    r.total_regions = count;
    r.overflow = (count > MAX_REGIONS);
    r.last_result = 1;
    expected_recs.push_back(r);
  endtask

  // Offer one pixel beat and wait until it is taken.
  task automatic send_pixel(logic [7:0] pix, logic fend);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tlast  <= fend;
    do @(posedge clk); while (!s_tready);
    predict_pixel(pix, fend);
    items_sent++;
  endtask

  // Wait until every expected record has arrived and the block settles.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_recs.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ROWS:      rows_reg = val;
      REG_COLS:      cols_reg = val;
      REG_THRESHOLD: thresh_reg = val[7:0];
      default:       seed_reg = val[7:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int rows, int cols, int thr, int seed);
    write_reg(REG_ROWS, rows[8:0]);
    write_reg(REG_COLS, cols[8:0]);
    write_reg(REG_THRESHOLD, {1'($urandom_range(1)), thr[7:0]});
    write_reg(REG_SEED, {1'($urandom_range(1)), seed[7:0]});
  endtask

  // Pixel with a mix of seeds, growable and blocking values, or pure noise.
  function automatic logic [7:0] pick_pixel(bit noisy);
    int k;
    if (noisy) return 8'($urandom_range(255));
    k = $urandom_range(99);
    if (k < 20) return seed_reg;
    if (k < 60 && thresh_reg > 0) return 8'($urandom_range(int'(thresh_reg) - 1));
    return 8'($urandom_range(255, int'(thresh_reg)));
  endfunction

  // Random frame; short frames only where every address still in use was loaded.
  task automatic send_random_frame();
    int n, len;
    bit noisy;
    n = clamp_dim(rows_reg, MAX_ROWS) * clamp_dim(cols_reg, MAX_COLS);
    noisy = ($urandom_range(99) < 20);
    len = n;
    if (loaded_span < n) len = n + $urandom_range(2);
    else if ($urandom_range(99) < 15 && n > 1) len = $urandom_range(n - 1, 1);
    else if ($urandom_range(99) < 15) len = n + $urandom_range(4, 1);
    for (int i = 0; i < len; i++) send_pixel(pick_pixel(noisy), i == len - 1);
  endtask

  task automatic send_list(logic [7:0] pixels[]);
    foreach (pixels[i]) send_pixel(pixels[i], i == pixels.size() - 1);
  endtask

  // Small hand-made frames: border seeds and a seed not below threshold.
  task automatic test_directed();
    set_config(3, 4, 10, 0);
    send_list('{8'd0, 8'd5, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd9,
                8'd0, 8'd255, 8'd1, 8'd255});
    wait_drained();
    write_reg(REG_SEED, 9'd200);
    send_list('{8'd200, 8'd3, 8'd255, 8'd128, 8'd255, 8'd200, 8'd0, 8'd200,
                8'd255, 8'd255, 8'd255, 8'd200});
    wait_drained();
  endtask

  // Size registers at zero and beyond the maximum; the large frame also overflows.
  task automatic test_size_extremes();
    // Seed level at or above threshold: every seed is its own region.
    set_config(511, 1, 0, 255);
    for (int i = 0; i < 256; i++) send_pixel(8'd255, i == 255);
    wait_drained();
    set_config(0, 0, 1, 0);
    send_random_frame();
    send_random_frame();
    wait_drained();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int budget);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(9) == 0)
        set_config($urandom_range(10, 1), $urandom_range(10, 1),
                   $urandom_range(255), $urandom_range(255));
      else
        set_config($urandom_range(6, 1), $urandom_range(6, 1),
                   $urandom_range(255), $urandom_range(255));
      repeat ($urandom_range(3, 1)) send_random_frame();
      wait_drained();
    end
  endtask

  // Output held off while two frames are offered back to back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(4, 5, 100, 20);
    hold_cycles = 600;
    send_random_frame();
    send_random_frame();
    wait_drained();
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result side: random stalls, long hold-offs and the record check.
  always @(posedge clk) begin
    region_rec_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_recs.size() == 0) begin
          $error("result beat with no expected record");
          fail_count++;
        end else begin
          e = expected_recs.pop_front();
          check_field("region_index", e.region_index, m_tdata[14:0]);
          check_field("top_row", e.top_row, m_tdata[22:15]);
          check_field("bottom_row", e.bottom_row, m_tdata[30:23]);
          check_field("left_col", e.left_col, m_tdata[38:31]);
          check_field("right_col", e.right_col, m_tdata[46:39]);
          check_field("total_regions", e.total_regions, m_tdata[61:47]);
          check_field("overflow", e.overflow, m_tdata[62]);
          check_field("spare bit", 0, m_tdata[63]);
          check_field("is_summary", e.is_summary, m_tuser);
          check_field("last_result", e.last_result, m_tlast);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_ROWS;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    rows_reg = ROWS_RST;
    cols_reg = COLS_RST;
    thresh_reg = THRESHOLD_RST;
    seed_reg = SEED_RST;
    load_pos = 0;
    loaded_span = 0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_size_extremes();
    test_random_phase(0, 0, 20);
    test_random_phase(59, 0, 20);
    test_random_phase(0, 59, 20);
    test_random_phase(26, 26, 20);
    test_backpressure();

    if (fail_count == 0 && expected_recs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
